/* rtl/pnlt_pkg.sv */
package pnlt_pkg;

   localparam int CMD_W    = 3;
   localparam int PIDX_W   = 10;
   localparam int PCNT_W   = 11;
   localparam int DIST_W   = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;
   localparam int PAIR_W   = PIDX_W + DIST_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_BEGIN  = 3'd1,
      CMD_ADD    = 3'd2,
      CMD_COMMIT = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_STAGE_FULL = 2'd1,
      ST_STORE_FULL = 2'd2,
      ST_RANGE      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SWEEP,
      S_COPY,
      S_COPY_END,
      S_QDIR,
      S_QSTORE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep;
      logic copy;
      logic copy_end;
      logic qdir;
      logic qstore;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    clear_empty;
      logic    commit_go;
      logic    query_go;
      logic    slot_ok;
      logic    sweep_last;
      logic    copy_last;
      logic    rsp_free;
   } stat_type;

endpackage

/* rtl/pnlt_req_if.sv */
interface pnlt_req_if;
   import pnlt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [PIDX_W-1:0] point_index;
   logic [PCNT_W-1:0] point_count;
   logic [DIST_W-1:0] distance_bits;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, cmd, point_index, point_count, distance_bits, slot,
                   input ready);
   modport sink (input valid, cmd, point_index, point_count, distance_bits, slot,
                 output ready);
endinterface

/* rtl/pnlt_rsp_if.sv */
interface pnlt_rsp_if;
   import pnlt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PIDX_W-1:0]   neighbor_point;
   logic [DIST_W-1:0]   neighbor_distance;
   logic [LEN_W-1:0]    list_length;

   modport source (output valid, status, neighbor_point, neighbor_distance, list_length,
                   input ready);
   modport sink (input valid, status, neighbor_point, neighbor_distance, list_length,
                 output ready);
endinterface

/* rtl/pnlt_ctrl.sv */
module pnlt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pnlt_pkg::stat_type stat,
   output pnlt_pkg::ctrl_type ctrl
);
   import pnlt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.exec = 1'b1;
            case (stat.cmd)
               CMD_CLEAR:  state_in = stat.clear_empty ? S_DONE : S_SWEEP;
               CMD_COMMIT: state_in = stat.commit_go ? S_COPY : S_DONE;
               CMD_QUERY:  state_in = stat.query_go ? S_QDIR : S_DONE;
               default:    state_in = S_DONE;
            endcase
         end
         S_SWEEP: begin
            ctrl.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            ctrl.copy = 1'b1;
            if (stat.copy_last) begin
               state_in = S_COPY_END;
            end
         end
         S_COPY_END: begin
            ctrl.copy_end = 1'b1;
            state_in      = S_DONE;
         end
         S_QDIR: begin
            ctrl.qdir = 1'b1;
            state_in  = stat.slot_ok ? S_QSTORE : S_DONE;
         end
         S_QSTORE: begin
            ctrl.qstore = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output word is free
            if (stat.rsp_free) begin
               ctrl.finish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/pnlt_dpath.sv */
module pnlt_dpath #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_NEIGHBORS = 64,
   parameter int PAIR_DEPTH    = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pnlt_pkg::CMD_W-1:0]  req_cmd,
   input  logic [pnlt_pkg::PIDX_W-1:0] req_point_index,
   input  logic [pnlt_pkg::PCNT_W-1:0] req_point_count,
   input  logic [pnlt_pkg::DIST_W-1:0] req_distance_bits,
   input  logic [pnlt_pkg::SLOT_W-1:0] req_slot,
   input  pnlt_pkg::ctrl_type          ctrl,
   output pnlt_pkg::stat_type          stat,
   pnlt_rsp_if.source                  rsp_bus
);
   import pnlt_pkg::*;

   localparam int PW    = $clog2(MAX_POINTS);
   localparam int AW    = $clog2(MAX_POINTS + 1);
   localparam int NW    = $clog2(MAX_NEIGHBORS + 1);
   localparam int SW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int OW    = $clog2(PAIR_DEPTH);
   localparam int FW    = $clog2(PAIR_DEPTH + 1);
   localparam int QW    = OW + 1;
   localparam int DIR_W = NW + OW;

   // latched request
   cmd_type           cmd_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [PCNT_W-1:0] pcnt_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [SLOT_W-1:0] slot_ff;

   // control state
   logic [NW-1:0]     staged_ff;
   logic [PIDX_W-1:0] current_ff;
   logic [FW-1:0]     fill_ff;
   logic [AW-1:0]     active_ff;
   logic [PW-1:0]     sweep_ff;
   logic [SW-1:0]     copy_k_ff;
   logic              copy_vld_ff;
   logic [OW-1:0]     copy_wa_ff;
   logic              rsp_valid_ff;

   // memories
   logic [DIR_W-1:0]  dir_mem [MAX_POINTS];
   logic [DIR_W-1:0]  dir_rd_ff;
   logic [PAIR_W-1:0] stage_mem [MAX_NEIGHBORS];
   logic [PAIR_W-1:0] stage_rd_ff;
   logic [PAIR_W-1:0] store_mem [PAIR_DEPTH];
   logic [PAIR_W-1:0] store_rd_ff;

   // result being built and the output word
   status_type        res_status_ff;
   logic [PIDX_W-1:0] res_point_ff;
   logic [DIST_W-1:0] res_dist_ff;
   logic [LEN_W-1:0]  res_len_ff;
   logic              res_query_ff;
   status_type        rsp_status_ff;
   logic [PIDX_W-1:0] rsp_point_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic [AW-1:0]     act_sat;
   logic              pidx_in_range;
   logic              cur_in_range;
   logic              stage_empty;
   logic              stage_full;
   logic              store_fits;
   logic              commit_go;
   logic [NW-1:0]     dir_rd_cnt;
   logic [OW-1:0]     dir_rd_off;
   logic [QW-1:0]     q_at;
   logic              slot_ok;
   logic              rsp_free;
   logic              add_we;
   logic              dir_we;
   logic [PW-1:0]     dir_wa;
   logic [DIR_W-1:0]  dir_wd;

   assign act_sat = (32'(pcnt_ff) > MAX_POINTS) ? AW'(MAX_POINTS) : AW'(pcnt_ff);
   assign pidx_in_range = 32'(pidx_ff) < 32'(active_ff);
   assign cur_in_range  = 32'(current_ff) < 32'(active_ff);
   assign stage_empty   = (staged_ff == '0);
   assign stage_full    = 32'(staged_ff) >= MAX_NEIGHBORS;
   assign store_fits    = (32'(fill_ff) + 32'(staged_ff)) <= PAIR_DEPTH;
   assign commit_go     = !stage_empty && cur_in_range && store_fits;
   assign dir_rd_cnt    = dir_rd_ff[DIR_W-1:OW];
   assign dir_rd_off    = dir_rd_ff[OW-1:0];
   assign q_at          = {1'b0, dir_rd_off} + QW'(slot_ff);
   assign slot_ok       = (32'(slot_ff) < 32'(dir_rd_cnt)) && (32'(q_at) < PAIR_DEPTH);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign add_we = ctrl.exec && (cmd_ff == CMD_ADD) && !stage_full;
   assign dir_we = ctrl.sweep || (ctrl.exec && (cmd_ff == CMD_COMMIT) && commit_go);
   assign dir_wa = ctrl.sweep ? sweep_ff : PW'(current_ff);
   assign dir_wd = ctrl.sweep ? '0 : {staged_ff, OW'(fill_ff)};

   assign stat.cmd         = cmd_ff;
   assign stat.clear_empty = (act_sat == '0);
   assign stat.commit_go   = commit_go;
   assign stat.query_go    = pidx_in_range;
   assign stat.slot_ok     = slot_ok;
   assign stat.sweep_last  = 32'(sweep_ff) == (32'(active_ff) - 32'd1);
   assign stat.copy_last   = 32'(copy_k_ff) == (32'(staged_ff) - 32'd1);
   assign stat.rsp_free    = rsp_free;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         pidx_ff <= req_point_index;
         pcnt_ff <= req_point_count;
         dist_ff <= req_distance_bits;
         slot_ff <= req_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         staged_ff    <= '0;
         current_ff   <= '0;
         fill_ff      <= '0;
         active_ff    <= '0;
         sweep_ff     <= '0;
         copy_k_ff    <= '0;
         copy_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         copy_vld_ff <= ctrl.copy;
         if (ctrl.exec) begin
            case (cmd_ff)
               CMD_CLEAR: begin
                  active_ff <= act_sat;
                  fill_ff   <= '0;
                  sweep_ff  <= '0;
               end
               CMD_BEGIN: begin
                  current_ff <= pidx_ff;
                  staged_ff  <= '0;
               end
               CMD_ADD: begin
                  if (!stage_full) begin
                     staged_ff <= staged_ff + NW'(1);
                  end
               end
               CMD_COMMIT: copy_k_ff <= '0;
               default: ;
            endcase
         end
         if (ctrl.sweep) begin
            sweep_ff <= sweep_ff + PW'(1);
         end
         if (ctrl.copy) begin
            copy_k_ff <= copy_k_ff + SW'(1);
         end
         if (ctrl.copy_end) begin
            fill_ff <= fill_ff + FW'(staged_ff);
         end
         if (ctrl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.copy) begin
         copy_wa_ff <= OW'(32'(fill_ff) + 32'(copy_k_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_wa] <= dir_wd;
      end
      dir_rd_ff <= dir_mem[PW'(pidx_ff)];
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         stage_mem[SW'(staged_ff)] <= {pidx_ff, dist_ff};
      end
      stage_rd_ff <= stage_mem[copy_k_ff];
   end

   always_ff @(posedge clock) begin
      if (copy_vld_ff) begin
         store_mem[copy_wa_ff] <= stage_rd_ff;
      end
      store_rd_ff <= store_mem[q_at[OW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         res_status_ff <= ST_OK;
         res_point_ff  <= '0;
         res_dist_ff   <= '0;
         res_len_ff    <= '0;
         res_query_ff  <= (cmd_ff == CMD_QUERY);
         case (cmd_ff)
            CMD_BEGIN: begin
               if (!pidx_in_range) begin
                  res_status_ff <= ST_RANGE;
               end
            end
            CMD_ADD: begin
               if (stage_full) begin
                  res_status_ff <= ST_STAGE_FULL;
               end
            end
            CMD_COMMIT: begin
               if (stage_empty) begin
                  res_status_ff <= ST_OK;
               end else if (!cur_in_range) begin
                  res_status_ff <= ST_RANGE;
               end else if (!store_fits) begin
                  res_status_ff <= ST_STORE_FULL;
               end
            end
            CMD_QUERY: begin
               if (!pidx_in_range) begin
                  res_status_ff <= ST_RANGE;
               end
            end
            default: ;
         endcase
      end
      if (ctrl.qdir) begin
         res_len_ff <= LEN_W'(dir_rd_cnt);
         if (!slot_ok) begin
            res_status_ff <= ST_RANGE;
         end
      end
      if (ctrl.qstore) begin
         res_point_ff <= store_rd_ff[PAIR_W-1:DIST_W];
         res_dist_ff  <= store_rd_ff[DIST_W-1:0];
      end
      if (ctrl.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_point_ff  <= res_point_ff;
         rsp_dist_ff   <= res_dist_ff;
         rsp_len_ff    <= res_query_ff ? res_len_ff : LEN_W'(staged_ff);
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_status_ff;
   assign rsp_bus.neighbor_point    = rsp_point_ff;
   assign rsp_bus.neighbor_distance = rsp_dist_ff;
   assign rsp_bus.list_length       = rsp_len_ff;

`ifndef SYNTHESIS
   a_staged_bound: assert property (@(posedge clock) disable iff (reset)
      32'(staged_ff) <= MAX_NEIGHBORS)
      else $error("staged count above list depth");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= PAIR_DEPTH)
      else $error("fill offset past pair store");
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) <= MAX_POINTS)
      else $error("active point count above directory depth");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> rsp_free)
      else $error("result loaded over a pending word");
   a_copy_write: assert property (@(posedge clock) disable iff (reset)
      copy_vld_ff |-> (32'(copy_wa_ff) < 32'(fill_ff) + 32'(staged_ff)))
      else $error("pair write outside the committed run");
`endif

endmodule

/* rtl/packed_neighbor_list_table_unit.sv */
// channel   dir  handshake      payload
// req_bus   in   valid/ready    cmd, point_index, point_count, distance_bits, slot
// rsp_bus   out  valid/ready    status, neighbor_point, neighbor_distance, list_length
//
// Begin, add and unused commands are executed and then answered; a query also reads the
// directory, then the pair store if the slot is in range. A commit copies one staged pair
// per cycle through the staging RAM read port. A clear sweeps the directory one entry per
// cycle over the active point count.
// Reset is synchronous; the directory is only read after a clear, so no pass follows reset.
// One item is worked at a time; a new item is taken while the last result waits on rsp_bus.
module packed_neighbor_list_table_unit #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_NEIGHBORS = 64,
   parameter int PAIR_DEPTH    = 16384
) (
   input logic        clock,
   input logic        reset,
   pnlt_req_if.sink   req_bus,
   pnlt_rsp_if.source rsp_bus
);
   import pnlt_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     req_ready;

   assign req_bus.ready = req_ready;

   pnlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   pnlt_dpath #(
      .MAX_POINTS    (MAX_POINTS),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .PAIR_DEPTH    (PAIR_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_bus.cmd),
      .req_point_index   (req_bus.point_index),
      .req_point_count   (req_bus.point_count),
      .req_distance_bits (req_bus.distance_bits),
      .req_slot          (req_bus.slot),
      .ctrl              (ctrl),
      .stat              (stat),
      .rsp_bus           (rsp_bus)
   );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import pnlt_pkg::*;

   localparam int N_POINTS    = 1024;
   localparam int N_NEIGHBORS = 64;
   localparam int N_PAIRS     = 16384;
   localparam int N_ITEMS     = 1250;

   // commands without a meaning in the block
   localparam logic [CMD_W-1:0] CMD_NOP_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NOP_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP_C = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [PIDX_W-1:0] pidx;
      logic [PCNT_W-1:0] pcnt;
      logic [DIST_W-1:0] dist_bits;
      logic [SLOT_W-1:0] slot;
   } req_word_t;

   typedef struct packed {
      status_type        status;
      logic [PIDX_W-1:0] npoint;
      logic [DIST_W-1:0] ndist;
      logic [LEN_W-1:0]  length;
   } rsp_word_t;

   typedef struct {
      req_word_t   req;
      int          reps;
      int          typed;
      status_type  status;
      int          length;
   } table_row_t;

   logic clock;
   logic reset;

   pnlt_req_if req_bus ();
   pnlt_rsp_if rsp_bus ();

   packed_neighbor_list_table_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // predictor state
   int unsigned pt_count [N_POINTS];
   int unsigned pt_offset [N_POINTS];
   logic [PIDX_W-1:0] pair_point [N_PAIRS];
   logic [DIST_W-1:0] pair_dist [N_PAIRS];
   logic [PIDX_W-1:0] stage_point [N_NEIGHBORS];
   logic [DIST_W-1:0] stage_dist [N_NEIGHBORS];
   int unsigned staged, cur_point, fill, active;

   rsp_word_t pending_rsps [$];
   int errors = 0;
   int items_sent = 0;
   int rsps_seen = 0;
   int store_full_seen = 0;
   int stage_full_seen = 0;
   int good_queries = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   bit long_hold_req = 0;
   int hold_left = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic rsp_word_t table_step(input req_word_t r);
      rsp_word_t o;
      o = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_CLEAR: begin
            active = (r.pcnt > N_POINTS) ? N_POINTS : r.pcnt;
            foreach (pt_count[i]) begin
               pt_count[i] = 0;
               pt_offset[i] = 0;
            end
            fill = 0;
         end
         CMD_BEGIN: begin
            cur_point = r.pidx;
            staged = 0;
            if (r.pidx >= active) o.status = ST_RANGE;
         end
         CMD_ADD: begin
            if (staged >= N_NEIGHBORS) begin
               o.status = ST_STAGE_FULL;
            end else begin
               stage_point[staged] = r.pidx;
               stage_dist[staged] = r.dist_bits;
               staged++;
            end
         end
         CMD_COMMIT: begin
            if (staged == 0) o.status = ST_OK;
            else if (cur_point >= active) o.status = ST_RANGE;
            else if (fill + staged > N_PAIRS) o.status = ST_STORE_FULL;
            else begin
               for (int k = 0; k < staged; k++) begin
                  pair_point[fill + k] = stage_point[k];
                  pair_dist[fill + k] = stage_dist[k];
               end
               pt_count[cur_point] = staged;
               pt_offset[cur_point] = fill;
               fill += staged;
            end
         end
         default: ;
      endcase
      o.length = LEN_W'(staged);
      if (r.cmd == CMD_QUERY) begin
         if (r.pidx >= active) begin
            o.status = ST_RANGE;
            o.length = '0;
         end else begin
            o.length = LEN_W'(pt_count[r.pidx]);
            if (r.slot >= pt_count[r.pidx]) o.status = ST_RANGE;
            else begin
               o.npoint = pair_point[pt_offset[r.pidx] + r.slot];
               o.ndist = pair_dist[pt_offset[r.pidx] + r.slot];
            end
         end
      end
      return o;
   endfunction

   // drive one word, wait for acceptance, then record its expected result
   task automatic send_word(input req_word_t r, output rsp_word_t o);
      bit acc;
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= r.cmd;
      req_bus.point_index <= r.pidx;
      req_bus.point_count <= r.pcnt;
      req_bus.distance_bits <= r.dist_bits;
      req_bus.slot <= r.slot;
      do begin
         @(negedge clock);
         acc = req_bus.ready;
         @(posedge clock);
      end while (!acc);
      o = table_step(r);
      items_sent++;
      if (o.status == ST_STORE_FULL) store_full_seen++;
      if (o.status == ST_STAGE_FULL) stage_full_seen++;
      if (r.cmd == CMD_QUERY && o.status == ST_OK) good_queries++;
   endtask

   task automatic send_checked(input req_word_t r);
      rsp_word_t o;
      send_word(r, o);
      pending_rsps.push_back(o);
   endtask

   function automatic req_word_t make_word(input logic [CMD_W-1:0] c,
                                           input int unsigned p, input int unsigned n,
                                           input logic [DIST_W-1:0] d, input int unsigned s);
      req_word_t r;
      r.cmd = c;
      r.pidx = PIDX_W'(p);
      r.pcnt = PCNT_W'(n);
      r.dist_bits = d;
      r.slot = SLOT_W'(s);
      return r;
   endfunction

   function automatic int unsigned pick_point();
      if (active == 0 || $urandom_range(19) == 0) return $urandom_range(N_POINTS - 1);
      return $urandom_range(active - 1);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (long_hold_req) begin
            hold_left = 300;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(negedge clock) begin
      rsp_word_t got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = status_type'(rsp_bus.status);
         got.npoint = rsp_bus.neighbor_point;
         got.ndist = rsp_bus.neighbor_distance;
         got.length = rsp_bus.list_length;
         rsps_seen++;
         if (pending_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", got);
         end else begin
            want = pending_rsps.pop_front();
            if (got.status !== want.status || got.npoint !== want.npoint ||
                got.ndist !== want.ndist || got.length !== want.length) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at result %0d: expected %s pt=%0d dist=%h len=%0d,",
                           rsps_seen, want.status.name(), want.npoint, want.ndist,
                           want.length);
                  $display("   got %s pt=%0d dist=%h len=%0d",
                           got.status.name(), got.npoint, got.ndist, got.length);
               end
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      table_row_t dir_rows [$];
      table_row_t row;
      rsp_word_t o;
      int unsigned p, k, n, sel;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_CLEAR;
      req_bus.point_index = '0;
      req_bus.point_count = '0;
      req_bus.distance_bits = '0;
      req_bus.slot = '0;
      staged = 0;
      cur_point = 0;
      fill = 0;
      active = 0;
      foreach (pt_count[i]) begin
         pt_count[i] = 0;
         pt_offset[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         '{make_word(CMD_QUERY, 0, 0, 0, 0), 1, 1, ST_RANGE, 0},
         '{make_word(CMD_BEGIN, 5, 0, 0, 0), 1, 1, ST_RANGE, 0},
         '{make_word(CMD_ADD, 0, 0, 32'h0, 0), 1, 1, ST_OK, 1},
         '{make_word(CMD_COMMIT, 0, 0, 0, 0), 1, 1, ST_RANGE, 1},
         '{make_word(CMD_CLEAR, 0, 2047, 0, 0), 1, 1, ST_OK, 1},
         '{make_word(CMD_COMMIT, 0, 0, 0, 0), 1, 0, ST_OK, 0},
         '{make_word(CMD_QUERY, 5, 0, 0, 0), 1, 0, ST_OK, 0},
         '{make_word(CMD_QUERY, 5, 0, 0, 63), 1, 1, ST_RANGE, 1},
         '{make_word(CMD_BEGIN, 1023, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_ADD, 1023, 0, 32'hFFFF_FFFF, 0), 65, 0, ST_OK, 0},
         '{make_word(CMD_COMMIT, 0, 0, 0, 0), 1, 0, ST_OK, 0},
         '{make_word(CMD_QUERY, 1023, 0, 0, 63), 1, 0, ST_OK, 0},
         '{make_word(CMD_COMMIT, 0, 0, 0, 0), 1, 0, ST_OK, 0},
         '{make_word(CMD_QUERY, 1023, 0, 0, 0), 1, 0, ST_OK, 0},
         '{make_word(CMD_BEGIN, 0, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_COMMIT, 0, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_NOP_A, 1023, 2047, 32'hFFFF_FFFF, 63), 1, 1, ST_OK, 0},
         '{make_word(CMD_NOP_B, 0, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_NOP_C, 0, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_CLEAR, 0, 0, 0, 0), 1, 1, ST_OK, 0},
         '{make_word(CMD_QUERY, 0, 0, 0, 0), 1, 1, ST_RANGE, 0},
         '{make_word(CMD_BEGIN, 0, 0, 0, 0), 1, 1, ST_RANGE, 0},
         '{make_word(CMD_CLEAR, 0, 1024, 0, 0), 1, 1, ST_OK, 0}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         for (int j = 0; j < row.reps; j++) begin
            send_word(row.req, o);
            if (row.typed != 0) o = '{row.status, '0, '0, row.length[LEN_W-1:0]};
            pending_rsps.push_back(o);
         end
      end

      // fill the pair store by committing one full list over and over
      send_checked(make_word(CMD_BEGIN, 700, 0, 0, 0));
      for (k = 0; k < N_NEIGHBORS; k++)
         send_checked(make_word(CMD_ADD, $urandom_range(1023), 0, $urandom, 0));
      for (k = 0; k < 258; k++) send_checked(make_word(CMD_COMMIT, 0, 0, 0, 0));
      send_checked(make_word(CMD_QUERY, 700, 0, 0, $urandom_range(63)));
      send_checked(make_word(CMD_CLEAR, 0, 1024, 0, 0));

      while (items_sent < N_ITEMS) begin
         case ((items_sent / 160) % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 73; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 73; end
            default: begin send_gap_pct = 34; stall_pct = 34; end
         endcase
         if (items_sent > 500 && items_sent < 520 && hold_left == 0 && !long_hold_req)
            long_hold_req = 1;
         if (items_sent > 900 && items_sent < 910) wait (pending_rsps.size() == 0);
         sel = $urandom_range(99);
         if (sel < 65) begin
            p = pick_point();
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
            send_checked(make_word(CMD_BEGIN, p, $urandom_range(2047), $urandom, $urandom));
            for (k = 0; k < n; k++)
               send_checked(make_word(CMD_ADD, $urandom_range(1023), $urandom_range(2047),
                                      $urandom, $urandom));
            send_checked(make_word(CMD_COMMIT, $urandom, $urandom, $urandom, $urandom));
            if ($urandom_range(4) == 0)
               send_checked(make_word(CMD_COMMIT, $urandom, $urandom, $urandom, $urandom));
            repeat ($urandom_range(1, 4))
               send_checked(make_word(CMD_QUERY, p, $urandom_range(2047), $urandom,
                                      $urandom_range(0, (n > 0 && n < 64) ? n : 63)));
         end else if (sel < 82) begin
            send_checked(make_word(CMD_QUERY, pick_point(), $urandom_range(2047), $urandom,
                                   $urandom_range(63)));
         end else if (sel < 96) begin
            send_checked(make_word(CMD_W'($urandom_range(1, 7)), $urandom_range(1023),
                                   $urandom_range(2047), $urandom, $urandom_range(63)));
         end else begin
            case ($urandom_range(3))
               0: n = $urandom_range(2047);
               1: n = $urandom_range(1, 32);
               default: n = 1024;
            endcase
            send_checked(make_word(CMD_CLEAR, $urandom_range(1023), n, $urandom,
                                   $urandom_range(63)));
         end
      end
      req_bus.valid <= 1'b0;
      send_gap_pct = 0;
      stall_pct = 0;

      wait (pending_rsps.size() == 0);
      repeat (40) @(posedge clock);

      $display("%0d words sent, %0d results checked: %0d good queries, %0d staging full,",
               items_sent, rsps_seen, good_queries, stage_full_seen);
      $display("%0d pair store full, across four idle/stall mixes", store_full_seen);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
